/* rtl/tfn_pkg.sv */
`timescale 1ns / 1ps

package tfn_pkg;

  // Newton steps of the reciprocal square root.
  localparam int RSQRT_ITER = 3;

  // Pipeline stage numbers, counted from the input register.
  localparam int ST_EDGE   = 0;
  localparam int ST_EMAG   = 1;
  localparam int ST_EFIT   = 2;
  localparam int ST_PROD   = 3;
  localparam int ST_CROSS  = 4;
  localparam int ST_CMAG   = 5;
  localparam int ST_CFIT   = 6;
  localparam int ST_SQ     = 7;
  localparam int ST_SUM    = 8;
  localparam int ST_SEED   = 9;
  localparam int ST_IT0    = 10;
  localparam int ST_NPROD  = ST_IT0 + 3 * RSQRT_ITER;
  localparam int ST_NRND   = ST_NPROD + 1;
  localparam int ST_OUT    = ST_NRND + 1;
  localparam int NUM_STG   = ST_OUT + 1;

  // Number of divide-by-three chunks and bits per chunk.
  localparam int DIV_CHUNKS = 4;
  localparam int DIV_BITS   = 9;

  // Offset that makes the centroid dividend positive: 3 * 2^31 plus the rounding one.
  localparam logic [35:0] DIV_BIAS  = 36'd6442450945;
  // 7.0 in Q28 for the seed.
  localparam logic [30:0] SEED_C    = 31'd1879048192;
  // 3.0 in Q30.
  localparam logic [31:0] THREE_Q30 = 32'hC000_0000;
  // 1.0 in Q16.16.
  localparam logic signed [19:0] Q_ONE = 20'sd65536;

  typedef struct packed {
    logic             degen;
    logic [2:0]       neg;
    logic [2:0][29:0] mag;
    logic [2:0][31:0] ctr;
  } side_t;

  typedef struct packed {
    logic [35:0] x;
    logic [35:0] q;
    logic [1:0]  rem;
  } div_t;

  typedef struct packed {
    logic [1:0] rem;
    logic [8:0] q;
  } d3_t;

  // Bit length of a magnitude: index of the highest set bit plus one.
  function automatic logic [5:0] bit_len48(input logic [47:0] v);
    logic [5:0] len;
    len = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) begin
        len = 6'(i + 1);
      end
    end
    return len;
  endfunction

  // Long division by three over one chunk of bits.
  function automatic d3_t div3_chunk(input logic [1:0] rem_in, input logic [8:0] bits);
    d3_t        res;
    logic [2:0] r3;
    res.rem = rem_in;
    res.q   = 9'd0;
    for (int i = 8; i >= 0; i--) begin
      r3 = {res.rem, bits[i]};
      if (r3 >= 3'd3) begin
        r3       = r3 - 3'd3;
        res.q[i] = 1'b1;
      end
      res.rem = r3[1:0];
    end
    return res;
  endfunction

  // Scale an edge magnitude so that the largest of the vector has 23 bits.
  function automatic logic [22:0] fit_edge(input logic [31:0] a, input logic [5:0] len);
    logic [31:0] t;
    if (len > 6'd23) begin
      t = a >> (len - 6'd23);
    end else begin
      t = a << (6'd23 - len);
    end
    return t[22:0];
  endfunction

  // Scale a cross magnitude so that the largest of the vector has 30 bits.
  function automatic logic [29:0] fit_cross(input logic [47:0] a, input logic [5:0] len);
    logic [47:0] t;
    if (len > 6'd30) begin
      t = a >> (len - 6'd30);
    end else begin
      t = a << (6'd30 - len);
    end
    return t[29:0];
  endfunction

endpackage

/* rtl/tfn_if.sv */
`timescale 1ns / 1ps

interface tfn_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] c_x;
  logic signed [31:0] c_y;
  logic signed [31:0] c_z;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface tfn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] center_z;
  logic signed [31:0] tip_x;
  logic signed [31:0] tip_y;
  logic signed [31:0] tip_z;

  modport source (output valid, center_x, center_y, center_z, tip_x, tip_y, tip_z,
                  input ready);
  modport sink (input valid, center_x, center_y, center_z, tip_x, tip_y, tip_z,
                output ready);
endinterface

/* rtl/triangle_face_normal.sv */
`timescale 1ns / 1ps

// Triangle face normal. One word on in_ch is one triangle (vertices A, B, C in
// signed Q16.16); one word on out_ch is its centroid and the tip, which is the
// centroid plus the unit face normal, saturated to 32 bits. A triangle whose
// cross product vanishes gets the normal (1, 0, 0).
// Both channels move a word on a clock edge where valid and ready are high.
// The pipeline has 22 register stages (13 stages plus three stages for each of
// the three Newton steps), and out_ch.valid rises once the accepted input word
// has passed through all of them. A new word may enter on every cycle while the
// output is not stalled, so the throughput is then one triangle per cycle; each
// stage holds one multiply or one wide add, which sets the clock.
// Each stage has its own valid bit and advances when it is empty or when the
// stage after it advances, so bubbles close up and a stalled output only
// backs up into the pipeline once every stage is full. Then in_ch.ready drops;
// nothing is lost or repeated while out_ch.ready is low.
// A synchronous active-low reset empties the pipeline; in_ch.ready is high
// from the first cycle after reset.
module triangle_face_normal (
  input  logic      clk,
  input  logic      rst_n,
  tfn_in_if.sink    in_ch,
  tfn_out_if.source out_ch
);

  localparam int NS = tfn_pkg::NUM_STG;
  localparam int NI = tfn_pkg::RSQRT_ITER;

  // Stage valid bits and per-stage advance enables.
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  assign en[NS-1] = !v_r[NS-1] || out_ch.ready;
  genvar gk;
  generate
    for (gk = 0; gk < NS - 1; gk++) begin : g_en
      assign en[gk] = !v_r[gk] || en[gk+1];
    end
  endgenerate

  assign in_ch.ready = en[0];
  assign out_ch.valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 0: edge vectors and the biased coordinate sums.
  logic signed [31:0] av [3];
  logic signed [31:0] bv [3];
  logic signed [31:0] cv [3];
  logic [32:0]        e1_nxt [3];
  logic [32:0]        e2_nxt [3];
  logic [33:0]        s_nxt [3];
  logic [35:0]        x_nxt [3];
  logic [32:0]        e1_r [3];
  logic [32:0]        e2_r [3];
  logic [35:0]        dx_r [3];

  assign av[0] = in_ch.a_x;
  assign av[1] = in_ch.a_y;
  assign av[2] = in_ch.a_z;
  assign bv[0] = in_ch.b_x;
  assign bv[1] = in_ch.b_y;
  assign bv[2] = in_ch.b_z;
  assign cv[0] = in_ch.c_x;
  assign cv[1] = in_ch.c_y;
  assign cv[2] = in_ch.c_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = {bv[i][31], bv[i]} - {av[i][31], av[i]};
      e2_nxt[i] = {cv[i][31], cv[i]} - {av[i][31], av[i]};
      s_nxt[i]  = {{2{av[i][31]}}, av[i]} + {{2{bv[i][31]}}, bv[i]}
                + {{2{cv[i][31]}}, cv[i]};
      x_nxt[i]  = {{2{s_nxt[i][33]}}, s_nxt[i]} + tfn_pkg::DIV_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_EDGE]) begin
      e1_r <= e1_nxt;
      e2_r <= e2_nxt;
      dx_r <= x_nxt;
    end
  end

  // Centroid: floor((sum + 1) / 3), done as biased long division, nine bits per
  // stage alongside the edge and cross stages.
  tfn_pkg::div_t div_r  [tfn_pkg::DIV_CHUNKS][3];

  genvar gj;
  generate
    for (gj = 0; gj < tfn_pkg::DIV_CHUNKS; gj++) begin : g_div
      localparam int STG = tfn_pkg::ST_EMAG + gj;
      localparam int TOP = 35 - tfn_pkg::DIV_BITS * gj;
      tfn_pkg::div_t prev [3];
      tfn_pkg::div_t nxt  [3];
      tfn_pkg::d3_t  dc   [3];
      if (gj == 0) begin : g_head
        always_comb begin
          for (int i = 0; i < 3; i++) begin
            prev[i].x   = dx_r[i];
            prev[i].q   = '0;
            prev[i].rem = 2'd0;
          end
        end
      end else begin : g_tail
        assign prev = div_r[gj-1];
      end
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          dc[i]                              = tfn_pkg::div3_chunk(prev[i].rem,
                                                 prev[i].x[TOP -: tfn_pkg::DIV_BITS]);
          nxt[i]                             = prev[i];
          nxt[i].q[TOP -: tfn_pkg::DIV_BITS] = dc[i].q;
          nxt[i].rem                         = dc[i].rem;
        end
      end
      always_ff @(posedge clk) begin
        if (en[STG]) begin
          div_r[gj] <= nxt;
        end
      end
    end
  endgenerate

  // Stage 1: edge magnitudes, signs and the bit length of each edge.
  logic [32:0] e1_neg [3];
  logic [32:0] e2_neg [3];
  logic [31:0] m1_nxt [3];
  logic [31:0] m2_nxt [3];
  logic [31:0] m1_r [3];
  logic [31:0] m2_r [3];
  logic [2:0]  n1_r;
  logic [2:0]  n2_r;
  logic [5:0]  l1_r;
  logic [5:0]  l2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_neg[i] = 33'd0 - e1_r[i];
      e2_neg[i] = 33'd0 - e2_r[i];
      m1_nxt[i] = e1_r[i][32] ? e1_neg[i][31:0] : e1_r[i][31:0];
      m2_nxt[i] = e2_r[i][32] ? e2_neg[i][31:0] : e2_r[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_EMAG]) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      n1_r <= {e1_r[2][32], e1_r[1][32], e1_r[0][32]};
      n2_r <= {e2_r[2][32], e2_r[1][32], e2_r[0][32]};
      l1_r <= tfn_pkg::bit_len48({16'd0, m1_nxt[0] | m1_nxt[1] | m1_nxt[2]});
      l2_r <= tfn_pkg::bit_len48({16'd0, m2_nxt[0] | m2_nxt[1] | m2_nxt[2]});
    end
  end

  // Stage 2: edges scaled to 23-bit magnitudes, back in two's complement.
  logic [22:0]        f1m [3];
  logic [22:0]        f2m [3];
  logic signed [23:0] f1_r [3];
  logic signed [23:0] f2_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f1m[i] = tfn_pkg::fit_edge(m1_r[i], l1_r);
      f2m[i] = tfn_pkg::fit_edge(m2_r[i], l2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_EFIT]) begin
      for (int i = 0; i < 3; i++) begin
        f1_r[i] <= n1_r[i] ? -$signed({1'b0, f1m[i]}) : $signed({1'b0, f1m[i]});
        f2_r[i] <= n2_r[i] ? -$signed({1'b0, f2m[i]}) : $signed({1'b0, f2m[i]});
      end
    end
  end

  // Stage 3: the six partial products of the cross product.
  logic signed [47:0] pr_r [6];

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_PROD]) begin
      pr_r[0] <= f1_r[1] * f2_r[2];
      pr_r[1] <= f1_r[2] * f2_r[1];
      pr_r[2] <= f1_r[2] * f2_r[0];
      pr_r[3] <= f1_r[0] * f2_r[2];
      pr_r[4] <= f1_r[0] * f2_r[1];
      pr_r[5] <= f1_r[1] * f2_r[0];
    end
  end

  // Stage 4: cross product components.
  logic [48:0] cr_r [3];

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_CROSS]) begin
      for (int i = 0; i < 3; i++) begin
        cr_r[i] <= {pr_r[2*i][47], pr_r[2*i]} - {pr_r[2*i+1][47], pr_r[2*i+1]};
      end
    end
  end

  // Stage 5: cross magnitudes, bit length, degenerate flag and the centroid.
  logic [48:0] cr_neg [3];
  logic [47:0] cm_nxt [3];
  logic [47:0] cm_r [3];
  logic [2:0]  cn_r;
  logic [5:0]  cl_r;
  logic        dg_r;
  logic [31:0] ctr5_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr_neg[i] = 49'd0 - cr_r[i];
      cm_nxt[i] = cr_r[i][48] ? cr_neg[i][47:0] : cr_r[i][47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_CMAG]) begin
      cm_r <= cm_nxt;
      cn_r <= {cr_r[2][48], cr_r[1][48], cr_r[0][48]};
      cl_r <= tfn_pkg::bit_len48(cm_nxt[0] | cm_nxt[1] | cm_nxt[2]);
      dg_r <= (cr_r[0] == '0) && (cr_r[1] == '0) && (cr_r[2] == '0);
      for (int i = 0; i < 3; i++) begin
        // Biased quotient minus 2^31, kept to 32 bits.
        ctr5_r[i] <= {~div_r[tfn_pkg::DIV_CHUNKS-1][i].q[31],
                      div_r[tfn_pkg::DIV_CHUNKS-1][i].q[30:0]};
      end
    end
  end

  // Stage 6 onward: the scaled cross vector and centroid ride in side_r.
  tfn_pkg::side_t side_r [tfn_pkg::ST_CFIT:tfn_pkg::ST_NPROD];
  tfn_pkg::side_t side_nxt;

  always_comb begin
    side_nxt.degen = dg_r;
    side_nxt.neg   = cn_r;
    for (int i = 0; i < 3; i++) begin
      side_nxt.mag[i] = tfn_pkg::fit_cross(cm_r[i], cl_r);
      side_nxt.ctr[i] = ctr5_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_CFIT]) begin
      side_r[tfn_pkg::ST_CFIT] <= side_nxt;
    end
  end

  generate
    for (gk = tfn_pkg::ST_CFIT + 1; gk <= tfn_pkg::ST_NPROD; gk++) begin : g_side
      always_ff @(posedge clk) begin
        if (en[gk]) begin
          side_r[gk] <= side_r[gk-1];
        end
      end
    end
  endgenerate

  // Stage 7: squares. Stage 8: squared length.
  logic [59:0] sq_r [3];
  logic [61:0] s_r;

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_SQ]) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= side_r[tfn_pkg::ST_CFIT].mag[i] * side_r[tfn_pkg::ST_CFIT].mag[i];
      end
    end
    if (en[tfn_pkg::ST_SUM]) begin
      s_r <= {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
    end
  end

  // Stage 9: u in Q28 within [1, 4), the shift choice and the linear seed.
  logic [29:0] u_r [tfn_pkg::ST_SEED:tfn_pkg::ST_NPROD-3];
  logic        h_r [tfn_pkg::ST_SEED:tfn_pkg::ST_NPROD];
  logic [30:0] rsq_r [NI+1];
  logic        h_nxt;
  logic [29:0] u_nxt;
  logic [30:0] sd_diff;
  logic [33:0] sd_x5;

  always_comb begin
    h_nxt   = |s_r[61:60];
    u_nxt   = h_nxt ? s_r[61:32] : s_r[59:30];
    sd_diff = tfn_pkg::SEED_C - {1'b0, u_nxt};
    sd_x5   = {1'b0, sd_diff, 2'b00} + {3'b000, sd_diff};
  end

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_SEED]) begin
      u_r[tfn_pkg::ST_SEED] <= u_nxt;
      h_r[tfn_pkg::ST_SEED] <= h_nxt;
      rsq_r[0]              <= sd_x5[33:3];
    end
  end

  generate
    for (gk = tfn_pkg::ST_SEED + 1; gk <= tfn_pkg::ST_NPROD - 3; gk++) begin : g_u
      always_ff @(posedge clk) begin
        if (en[gk]) begin
          u_r[gk] <= u_r[gk-1];
        end
      end
    end
    for (gk = tfn_pkg::ST_SEED + 1; gk <= tfn_pkg::ST_NPROD; gk++) begin : g_h
      always_ff @(posedge clk) begin
        if (en[gk]) begin
          h_r[gk] <= h_r[gk-1];
        end
      end
    end
  endgenerate

  // Newton steps, three stages each: q = r*r, p = u*q, r = r*(3 - p) / 2.
  genvar gi;
  generate
    for (gi = 0; gi < NI; gi++) begin : g_it
      localparam int SA = tfn_pkg::ST_IT0 + 3 * gi;
      logic [61:0] qq;
      logic [61:0] pp;
      logic [31:0] t_c;
      logic [62:0] rt;
      logic [31:0] q_r;
      logic [30:0] ra_r;
      logic [33:0] p_r;
      logic [30:0] rb_r;

      assign qq  = rsq_r[gi] * rsq_r[gi];
      assign pp  = u_r[SA] * q_r;
      assign t_c = (p_r > {2'b00, tfn_pkg::THREE_Q30}) ? 32'd0
                 : tfn_pkg::THREE_Q30 - p_r[31:0];
      assign rt  = rb_r * t_c;

      always_ff @(posedge clk) begin
        if (en[SA]) begin
          q_r  <= qq[61:30];
          ra_r <= rsq_r[gi];
        end
        if (en[SA+1]) begin
          p_r  <= pp[61:28];
          rb_r <= ra_r;
        end
        if (en[SA+2]) begin
          rsq_r[gi+1] <= rt[62] ? 31'h7FFF_FFFF : rt[61:31];
        end
      end
    end
  endgenerate

  // Normal products, then rounding, sign and the degenerate case.
  logic [60:0]        np_r [3];
  logic [61:0]        rsum [3];
  logic [18:0]        nv [3];
  logic signed [19:0] nrm_nxt [3];
  logic signed [19:0] nrm_r [3];
  logic [31:0]        ctr_r [3];

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_NPROD]) begin
      for (int i = 0; i < 3; i++) begin
        np_r[i] <= side_r[tfn_pkg::ST_NPROD-1].mag[i] * rsq_r[NI];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rsum[i] = {1'b0, np_r[i]}
              + (h_r[tfn_pkg::ST_NPROD] ? (62'd1 << 43) : (62'd1 << 42));
      nv[i]   = h_r[tfn_pkg::ST_NPROD] ? {1'b0, rsum[i][61:44]} : rsum[i][61:43];
      if (side_r[tfn_pkg::ST_NPROD].degen) begin
        nrm_nxt[i] = (i == 0) ? tfn_pkg::Q_ONE : 20'sd0;
      end else if (side_r[tfn_pkg::ST_NPROD].neg[i]) begin
        nrm_nxt[i] = -$signed({1'b0, nv[i]});
      end else begin
        nrm_nxt[i] = $signed({1'b0, nv[i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_NRND]) begin
      nrm_r <= nrm_nxt;
      for (int i = 0; i < 3; i++) begin
        ctr_r[i] <= side_r[tfn_pkg::ST_NPROD].ctr[i];
      end
    end
  end

  // Output register: centroid and saturated tip.
  logic [32:0] tsum [3];
  logic [31:0] tip_nxt [3];
  logic [31:0] center_r [3];
  logic [31:0] tip_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsum[i] = {ctr_r[i][31], ctr_r[i]} + {{13{nrm_r[i][19]}}, nrm_r[i]};
      if (tsum[i][32] != tsum[i][31]) begin
        tip_nxt[i] = tsum[i][32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        tip_nxt[i] = tsum[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[tfn_pkg::ST_OUT]) begin
      center_r <= ctr_r;
      tip_r    <= tip_nxt;
    end
  end

  assign out_ch.center_x = center_r[0];
  assign out_ch.center_y = center_r[1];
  assign out_ch.center_z = center_r[2];
  assign out_ch.tip_x    = tip_r[0];
  assign out_ch.tip_y    = tip_r[1];
  assign out_ch.tip_z    = tip_r[2];

  // The input only stalls when the whole pipeline is full behind a held word.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready))
    else $error("input stalled while the output stage is free");

  // A live cross vector leaves scaling with a full 30-bit largest magnitude.
  a_cross_fit: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[tfn_pkg::ST_CFIT] && !side_r[tfn_pkg::ST_CFIT].degen) |->
      (side_r[tfn_pkg::ST_CFIT].mag[0][29] || side_r[tfn_pkg::ST_CFIT].mag[1][29]
       || side_r[tfn_pkg::ST_CFIT].mag[2][29]))
    else $error("cross vector not scaled to 30 bits");

  // The seed input is normalized to at least 1.0 in Q28.
  a_u_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[tfn_pkg::ST_SEED] && !side_r[tfn_pkg::ST_SEED].degen) |->
      (u_r[tfn_pkg::ST_SEED][29:28] != 2'b00))
    else $error("squared length below range at the seed stage");

  // A word held at the output keeps the rest of the pipeline counted: the
  // output stage stays full for as long as the receiver stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("output word dropped under stall");

endmodule

/* bench/triangle_face_normal_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the triangle face normal block. Triangles are driven
// on the input channel with random idle bursts, results are taken from the
// output channel with random stall bursts, and each result is compared field
// by field against a bit-exact predictor kept in a small scoreboard class.
module triangle_face_normal_tb;

  localparam int NEWTON_STEPS = tfn_pkg::RSQRT_ITER;
  localparam int RANDOM_WORDS = 900;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  } tri_t;

  typedef struct packed {
    logic signed [31:0] center_x, center_y, center_z, tip_x, tip_y, tip_z;
  } face_t;

  // Holds the expected centroid/tip words in arrival order and computes them.
  class face_board;
    face_t pending[$];
    int    errors;
    int    checked;

    static function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return v < 0 ? -v : v;
    endfunction

    // Scale a vector in sign-magnitude so its largest magnitude has nbits bits.
    static function automatic void fit(ref logic signed [63:0] v[3], input int nbits);
      logic [63:0] m;
      logic [63:0] a;
      int          len;
      m = 0;
      len = 0;
      for (int i = 0; i < 3; i++) if (magnitude(v[i]) > m) m = magnitude(v[i]);
      for (int i = 0; i < 64; i++) if (m[i]) len = i + 1;
      if (len == 0) return;
      for (int i = 0; i < 3; i++) begin
        a = magnitude(v[i]);
        if (len > nbits) a = a >> (len - nbits);
        else a = a << (nbits - len);
        v[i] = v[i] < 0 ? -$signed(a) : $signed(a);
      end
    endfunction

    static function automatic logic signed [63:0] third_nearest(input logic signed [63:0] s);
      logic signed [63:0] x;
      x = s + 1;
      if (x >= 0) return x / 3;
      return -((-x + 2) / 3);
    endfunction

    static function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
      if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    static function automatic face_t predict(input tri_t t);
      logic signed [63:0] a[3], b[3], c[3], e1[3], e2[3], n[3], unit[3];
      logic [63:0] s, u, r, q, p, tt, m, v;
      logic signed [63:0] ctr[3];
      int h, sh;
      face_t f;
      a = '{t.a_x, t.a_y, t.a_z};
      b = '{t.b_x, t.b_y, t.b_z};
      c = '{t.c_x, t.c_y, t.c_z};
      for (int i = 0; i < 3; i++) begin
        e1[i] = b[i] - a[i];
        e2[i] = c[i] - a[i];
      end
      fit(e1, 23);
      fit(e2, 23);
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
        // Degenerate face: fall back to the x axis.
        unit = '{64'sd65536, 64'sd0, 64'sd0};
      end else begin
        fit(n, 30);
        s = 0;
        for (int i = 0; i < 3; i++) s += magnitude(n[i]) * magnitude(n[i]);
        if (s >= (64'd1 << 60)) begin
          u = s >> 32;
          h = 30;
        end else begin
          u = s >> 30;
          h = 29;
        end
        r = (64'd7 << 28) > u ? (((64'd7 << 28) - u) * 5) >> 3 : 0;
        for (int k = 0; k < NEWTON_STEPS; k++) begin
          q = (r * r) >> 30;
          p = (u * q) >> 28;
          tt = p > (64'd3 << 30) ? 0 : (64'd3 << 30) - p;
          r = (r * tt) >> 31;
          if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
        end
        sh = 14 + h;
        for (int i = 0; i < 3; i++) begin
          m = magnitude(n[i]);
          v = (m * r + (64'd1 << (sh - 1))) >> sh;
          unit[i] = n[i] < 0 ? -$signed(v) : $signed(v);
        end
      end
      for (int i = 0; i < 3; i++) ctr[i] = third_nearest(a[i] + b[i] + c[i]);
      f.center_x = ctr[0][31:0];
      f.center_y = ctr[1][31:0];
      f.center_z = ctr[2][31:0];
      f.tip_x = clip32(ctr[0] + unit[0]);
      f.tip_y = clip32(ctr[1] + unit[1]);
      f.tip_z = clip32(ctr[2] + unit[2]);
      return f;
    endfunction

    function void note_triangle(input tri_t t);
      pending = {pending, predict(t)};
    endfunction

    function void check_face(input face_t got);
      face_t want;
      if (pending.size() == 0) begin
        $error("face word with no triangle outstanding");
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.center_x !== want.center_x) begin
        $error("center_x expected %0d actual %0d", want.center_x, got.center_x); errors++;
      end
      if (got.center_y !== want.center_y) begin
        $error("center_y expected %0d actual %0d", want.center_y, got.center_y); errors++;
      end
      if (got.center_z !== want.center_z) begin
        $error("center_z expected %0d actual %0d", want.center_z, got.center_z); errors++;
      end
      if (got.tip_x !== want.tip_x) begin
        $error("tip_x expected %0d actual %0d", want.tip_x, got.tip_x); errors++;
      end
      if (got.tip_y !== want.tip_y) begin
        $error("tip_y expected %0d actual %0d", want.tip_y, got.tip_y); errors++;
      end
      if (got.tip_z !== want.tip_z) begin
        $error("tip_z expected %0d actual %0d", want.tip_z, got.tip_z); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  tfn_in_if  in_ch();
  tfn_out_if out_ch();

  triangle_face_normal dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  face_board board;
  tri_t      directed[$];
  int        sent;
  bit        quiet_tail;
  bit        hold_off;
  bit        stalled_seen;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Random 32-bit value biased toward the interesting corners.
  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 16)) - 8;
      4, 5: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic tri_t random_triangle();
    tri_t t;
    t.a_x = pick_coord(); t.a_y = pick_coord(); t.a_z = pick_coord();
    t.b_x = pick_coord(); t.b_y = pick_coord(); t.b_z = pick_coord();
    t.c_x = pick_coord(); t.c_y = pick_coord(); t.c_z = pick_coord();
    case ($urandom_range(0, 7))
      // Degenerate shapes: a repeated vertex, or three collinear points.
      0: {t.b_x, t.b_y, t.b_z} = {t.a_x, t.a_y, t.a_z};
      1: begin
        t.b_x = t.a_x + 32'sd65536; t.b_y = t.a_y + 32'sd131072; t.b_z = t.a_z;
        t.c_x = t.a_x + 32'sd131072; t.c_y = t.a_y + 32'sd262144; t.c_z = t.a_z;
      end
      // Triangle in a plane of constant x near the saturating corner, so the tip can clip.
      2: begin
        t.a_x = 32'sh7FFF_FF00; t.b_x = 32'sh7FFF_FF00; t.c_x = 32'sh7FFF_FF00;
      end
      default: ;
    endcase
    return t;
  endfunction

  // Appends one directed corner to the list sent after reset.
  function automatic void add_corner(input tri_t t);
    directed = {directed, t};
  endfunction

  task automatic send_triangle(input tri_t t);
    in_ch.valid <= 1'b1;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z,
     in_ch.c_x, in_ch.c_y, in_ch.c_z} <= t;
    @(posedge clk);
    while (!in_ch.ready) begin
      stalled_seen = 1'b1;
      @(posedge clk);
    end
    board.note_triangle(t);
    sent++;
  endtask

  task automatic sender_gap();
    int n;
    if (quiet_tail || $urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 12);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (120) @(posedge clk);
        hold_off = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 12);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Results are sampled at the edge where the handshake completes.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_face({out_ch.center_x, out_ch.center_y, out_ch.center_z,
                        out_ch.tip_x, out_ch.tip_y, out_ch.tip_z});
    end
  end

  initial begin
    #2_000_000;
    $display("triangle_face_normal verification failed");
    $finish;
  end

  initial begin
    int   waited;
    board = new();
    in_ch.valid <= 1'b0;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z, in_ch.b_x, in_ch.b_y, in_ch.b_z,
     in_ch.c_x, in_ch.c_y, in_ch.c_z} <= '0;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: unit right triangle, degenerate faces, extremes.
    add_corner('{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0, 32'sd0,
                 32'sd0, 32'sd65536, 32'sd0});
    add_corner('{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                 32'sd0, 32'sd0, 32'sd0});
    add_corner('{32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd5, 32'sd5,
                 32'sd9, 32'sd1, 32'sd3});
    add_corner('{32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd1, 32'sd1,
                 32'sd2, 32'sd2, 32'sd2});
    add_corner('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    add_corner('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    add_corner('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
    add_corner('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000});
    add_corner('{32'sh7FFF_FFF0, 32'sd0, 32'sd0, 32'sh7FFF_FFF0, 32'sd1, 32'sd0,
                 32'sh7FFF_FFF0, 32'sd0, 32'sd1});
    add_corner('{32'sh8000_0010, 32'sd0, 32'sd0, 32'sh8000_0010, 32'sd0, 32'sd1,
                 32'sh8000_0010, 32'sd1, 32'sd0});
    add_corner('{-32'sd1, -32'sd1, -32'sd1, 32'sd1, -32'sd1, -32'sd1,
                 -32'sd1, 32'sd1, -32'sd1});
    // Two long edges that differ only by one unit in y: the fit truncates that unit away.
    add_corner('{32'sd0, 32'sd0, 32'sd0, 32'sh7FFF_FFFF, 32'sd0, 32'sd0,
                 32'sh7FFF_FFFF, 32'sd1, 32'sd0});
    add_corner('{32'sd0, 32'sd0, 32'sd0, 32'sd3, 32'sd7, 32'sd11,
                 32'sd13, 32'sd2, 32'sd5});
    foreach (directed[i]) send_triangle(directed[i]);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 300) hold_off = 1'b1;
      if (i == RANDOM_WORDS - 100) quiet_tail = 1'b1;
      sender_gap();
      send_triangle(random_triangle());
    end
    in_ch.valid <= 1'b0;

    waited = 0;
    while (board.pending.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending.size() != 0) begin
      $error("%0d face words never arrived", board.pending.size());
      board.errors++;
    end

    $display("Sent %0d triangles (directed corners, degenerate faces, saturating tips);",
             sent);
    $display("checked %0d face words, input backpressure seen: %0d", board.checked,
             stalled_seen);
    if (board.errors == 0) begin
      $display("triangle_face_normal verification clean");
    end else begin
      $display("triangle_face_normal verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tfn_pkg.sv
rtl/tfn_if.sv
rtl/triangle_face_normal.sv
bench/triangle_face_normal_tb.sv
